### rtl/htwd_pkg.sv
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types and constants of the bit-serial Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package htwd_pkg;

  // Fixed field widths.
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned MAX_BITS = 8;

  // Default table depth.
  localparam int unsigned NODE_COUNT_DEF = 512;

  // One node of the tree as stored in the table.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             leaf;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] left;
  } node_entry_t;

  // Input beat.
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic              leaf_flag;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  valid_bits;
  } htwd_in_t;

  // Output beat.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } htwd_out_t;

  // Result handed from the walker to the output register.
  typedef struct packed {
    logic      valid;
    htwd_out_t beat;
  } htwd_push_t;

  // Input kinds.
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // True when a node index addresses an existing table entry.
  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx,
                                        input int unsigned count);
    return 32'(idx) < count;
  endfunction

endpackage

### rtl/htwd_node_ram.sv
// ----------------------------------------------------------------------------
// htwd_node_ram
// Node table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module htwd_node_ram #(
  parameter int unsigned DEPTH = htwd_pkg::NODE_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  htwd_pkg::node_entry_t wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output htwd_pkg::node_entry_t rd_data_o
);
  import htwd_pkg::*;

  node_entry_t mem [DEPTH];
  node_entry_t rd_data_q;

  // Write and registered read; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/htwd_walker.sv
// ----------------------------------------------------------------------------
// htwd_walker
// Sequencer that shifts a data byte out bit by bit and walks the node
// table, holding back each symbol until it is known whether it is the last.
// ----------------------------------------------------------------------------
module htwd_walker #(
  parameter int unsigned NODE_COUNT = htwd_pkg::NODE_COUNT_DEF,
  parameter int unsigned AW         = $clog2(NODE_COUNT)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  htwd_pkg::htwd_in_t           in_beat_i,
  input  logic [htwd_pkg::IDX_W-1:0]   root_i,
  input  logic                         out_free_i,
  output htwd_pkg::htwd_push_t         push_o,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output htwd_pkg::node_entry_t        wr_data_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_addr_o,
  input  htwd_pkg::node_entry_t        rd_data_i
);
  import htwd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_TEST,
    S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic [BYTE_W-1:0] shreg_q, shreg_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              oor_q, oor_d;
  logic              pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;

  node_entry_t       ent;
  logic [IDX_W-1:0]  child;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  nbits;

  // Entry at the last read address; an out-of-range index reads as zero.
  assign ent   = oor_q ? '0 : rd_data_i;
  assign child = shreg_q[BYTE_W-1] ? ent.right : ent.left;
  assign nbits = (in_beat_i.valid_bits > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                           : in_beat_i.valid_bits;

  assign rd_addr_o = AW'(rd_idx);

  // Table write path straight from the input beat.
  assign wr_addr_o = AW'(in_beat_i.node_index);
  assign wr_data_o = '{symbol: in_beat_i.leaf_symbol, leaf: in_beat_i.leaf_flag,
                       right: in_beat_i.right_child, left: in_beat_i.left_child};

  // Next-state logic of the walk sequencer.
  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    shreg_d      = shreg_q;
    cnt_d        = cnt_q;
    oor_d        = oor_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    in_ready_o   = 1'b0;
    wr_en_o      = 1'b0;
    rd_en_o      = 1'b0;
    rd_idx       = walk_q;
    push_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_beat_i.kind == KIND_NODE) begin
            wr_en_o = idx_in_range(in_beat_i.node_index, NODE_COUNT);
            walk_d  = root_i;
          end else if (nbits != '0) begin
            shreg_d = in_beat_i.data_byte;
            cnt_d   = nbits;
            rd_en_o = 1'b1;
            rd_idx  = walk_q;
            oor_d   = !idx_in_range(walk_q, NODE_COUNT);
            state_d = S_MOVE;
          end
        end
      end

      // Read data holds the current node: step to the child of the next bit.
      S_MOVE: begin
        rd_en_o = 1'b1;
        rd_idx  = child;
        oor_d   = !idx_in_range(child, NODE_COUNT);
        walk_d  = child;
        shreg_d = {shreg_q[BYTE_W-2:0], 1'b0};
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = S_TEST;
      end

      // Read data holds the node just reached.
      S_TEST: begin
        if (ent.leaf) begin
          if (!pend_valid_q || out_free_i) begin
            push_o.valid       = pend_valid_q;
            push_o.beat.symbol = pend_sym_q;
            push_o.beat.last   = 1'b0;
            pend_valid_d       = 1'b1;
            pend_sym_d         = ent.symbol;
            walk_d             = root_i;
            if (cnt_q != '0) begin
              rd_en_o = 1'b1;
              rd_idx  = root_i;
              oor_d   = !idx_in_range(root_i, NODE_COUNT);
              state_d = S_MOVE;
            end else begin
              state_d = S_FLUSH;
            end
          end
        end else if (cnt_q != '0) begin
          rd_en_o = 1'b1;
          rd_idx  = child;
          oor_d   = !idx_in_range(child, NODE_COUNT);
          walk_d  = child;
          shreg_d = {shreg_q[BYTE_W-2:0], 1'b0};
          cnt_d   = cnt_q - CNT_W'(1);
        end else begin
          state_d = S_FLUSH;
        end
      end

      // Send the held symbol as the last one of the byte.
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          push_o.valid       = 1'b1;
          push_o.beat.symbol = pend_sym_q;
          push_o.beat.last   = 1'b1;
          pend_valid_d       = 1'b0;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_q       <= '0;
      cnt_q        <= '0;
      oor_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      cnt_q        <= cnt_d;
      oor_q        <= oor_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q    <= shreg_d;
    pend_sym_q <= pend_sym_d;
  end

  // A result is only pushed into a free output register.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> out_free_i)
    else $error("walker pushed a result into a full output register");

  // The move step always sees freshly read node data.
  a_move_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_en_o |=> state_q != S_MOVE)
    else $error("move step entered without a table read");

  // The last beat of a byte empties the held symbol.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid && push_o.beat.last |=> !pend_valid_q && state_q == S_IDLE)
    else $error("held symbol survived the last beat");

  // The bit count never exceeds one byte.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BITS))
    else $error("bit count out of range");

endmodule

### rtl/huffman_tree_walk_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit
// Bit-serial Huffman decoder: loads a node table and walks it bit by bit,
// emitting one symbol beat for every leaf reached.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid/in_ready     htwd_in_t (node write or data)
//   out      output     out_valid/out_ready   htwd_out_t (symbol, last)
//   cfg      input      cfg_we (no wait)      root_node, 9 bits
//
// A node write or a data byte with no valid bits is done in its accept cycle.
// A data byte with valid bits passes in order through the accept, a read of
// the first child, a test of every node reached, one more table read for
// every symbol found with bits still left, and the close of the byte, an
// order set by the dependent registered read of the node table.
// Reset is asynchronous and needs no clearing pass; the table is undefined
// until written. A stalled output holds the walk when a symbol is found while
// an earlier one of the byte is held, and holds the close of the byte until
// the output register is free; the next item is taken while the final symbol
// waits in the output register.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_unit #(
  parameter int unsigned NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [htwd_pkg::IDX_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  htwd_pkg::htwd_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output htwd_pkg::htwd_out_t        out_data_o
);
  import htwd_pkg::*;

  localparam int unsigned AW = $clog2(NODE_COUNT);

  logic [IDX_W-1:0] root_q;
  logic             out_valid_q;
  htwd_out_t        out_beat_q;
  logic             out_free;
  htwd_push_t       push;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  node_entry_t      wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  node_entry_t      rd_data;

  // Root register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  // Output register parts the walker from the consumer.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_beat_q <= push.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  htwd_walker #(
    .NODE_COUNT(NODE_COUNT),
    .AW        (AW)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_beat_i (in_data_i),
    .root_i    (root_q),
    .out_free_i(out_free),
    .push_o    (push),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  htwd_node_ram #(
    .DEPTH(NODE_COUNT),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

### bench/huffman_tree_walk_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit_tb
// Self-checking bench for the tree-walk decoder. Node tables are loaded as
// full binary trees, the root register is moved between trees, and compressed
// bytes are pushed through. A behavioral copy of the table and the walk
// predicts every symbol beat, and each output beat is checked in order.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htwd_pkg::*;

  localparam int unsigned NODE_COUNT = NODE_COUNT_DEF;
  localparam int unsigned MAX_SLOTS  = 32;

  typedef logic [IDX_W-1:0] idx_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  idx_t      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  htwd_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  htwd_out_t out_data_o;

  huffman_tree_walk_decoder_unit #(.NODE_COUNT(NODE_COUNT)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Mirror of the decoder state.
  node_entry_t node_mirror [NODE_COUNT];
  idx_t        walk_mirror;
  idx_t        root_mirror;

  // Table entries written so far; every one of them has written children.
  bit          node_known [NODE_COUNT];
  idx_t        known_list [$];
  idx_t        tree_leaves [$];

  htwd_out_t   symbols_due [$];
  htwd_out_t   due_beat;
  int          mismatches;
  int          beats_sent;
  bit          in_gaps;
  bit          out_gaps;

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic node_entry_t fetch_node(input idx_t idx);
    if (32'(idx) >= NODE_COUNT) return '0;
    return node_mirror[idx];
  endfunction

  // Work out the symbol beats that one accepted input beat produces.
  task automatic decode_beat(input htwd_in_t beat);
    int          nbits;
    int          i;
    node_entry_t here;
    node_entry_t there;
    idx_t        step_to;
    htwd_out_t   held;
    bit          holding;
    holding = 1'b0;
    held    = '0;
    if (beat.kind == KIND_NODE) begin
      if (32'(beat.node_index) < NODE_COUNT) begin
        node_mirror[beat.node_index] = {beat.leaf_symbol, beat.leaf_flag,
                                        beat.right_child, beat.left_child};
        if (!node_known[beat.node_index]) begin
          node_known[beat.node_index] = 1'b1;
          known_list.push_back(beat.node_index);
        end
      end
      walk_mirror = root_mirror;
    end else begin
      nbits = (32'(beat.valid_bits) > MAX_BITS) ? int'(MAX_BITS) : int'(beat.valid_bits);
      for (i = 0; i < nbits; i++) begin
        here    = fetch_node(walk_mirror);
        step_to = beat.data_byte[BYTE_W-1-i] ? here.right : here.left;
        there   = fetch_node(step_to);
        walk_mirror = step_to;
        if (there.leaf) begin
          // The previous symbol of this byte is not the final one.
          if (holding) symbols_due.push_back(held);
          held.symbol = there.symbol;
          held.last   = 1'b0;
          holding     = 1'b1;
          walk_mirror = root_mirror;
        end
      end
      if (holding) begin
        held.last = 1'b1;
        symbols_due.push_back(held);
      end
    end
  endtask

  // Send one input beat, with random idle cycles ahead of it when input gaps are on.
  task automatic send_beat(input htwd_in_t beat);
    @(negedge clk_i);
    while (in_gaps && ($urandom_range(0, 99) < 23)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_beat(beat);
    beats_sent++;
  endtask

  // Wait until every expected beat is out, then let the walker go quiet.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic set_root(input idx_t root);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= root;
    root_mirror = root;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic htwd_in_t junk_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(htwd_in_t)-1:0];
  endfunction

  function automatic idx_t known_node();
    return known_list[$urandom_range(0, known_list.size() - 1)];
  endfunction

  task automatic send_node(input idx_t at, input idx_t left, input idx_t right,
                           input logic leaf, input logic [SYM_W-1:0] sym);
    htwd_in_t b;
    b = junk_beat();
    b.kind        = KIND_NODE;
    b.node_index  = at;
    b.left_child  = left;
    b.right_child = right;
    b.leaf_flag   = leaf;
    b.leaf_symbol = sym;
    send_beat(b);
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] bits, input logic [CNT_W-1:0] count);
    htwd_in_t b;
    b = junk_beat();
    b.kind       = KIND_DATA;
    b.data_byte  = bits;
    b.valid_bits = count;
    send_beat(b);
  endtask

  // Load a random full binary tree with the given root and leaf count.
  task automatic load_tree(input idx_t root, input int leaves);
    idx_t slot_idx [MAX_SLOTS];
    int   lc [MAX_SLOTS];
    int   rc [MAX_SLOTS];
    bit   is_leaf [MAX_SLOTS];
    bit   taken [NODE_COUNT];
    int   n_slots;
    int   pick;
    int   cand;
    int   s;
    int   k;
    taken = '{default: 1'b0};
    tree_leaves.delete();
    n_slots     = 1;
    slot_idx[0] = root;
    is_leaf[0]  = 1'b1;
    taken[root] = 1'b1;
    // Split random leaves until the leaf count is reached.
    repeat (leaves - 1) begin
      do pick = $urandom_range(0, n_slots - 1); while (!is_leaf[pick]);
      for (k = 0; k < 2; k++) begin
        do cand = $urandom_range(0, NODE_COUNT - 1); while (taken[cand]);
        taken[cand]       = 1'b1;
        slot_idx[n_slots] = idx_t'(cand);
        is_leaf[n_slots]  = 1'b1;
        if (k == 0) lc[pick] = n_slots;
        else rc[pick] = n_slots;
        n_slots++;
      end
      is_leaf[pick] = 1'b0;
    end
    // Leaf children point back into the tree so a leaf root stays walkable.
    for (s = 0; s < n_slots; s++) begin
      if (is_leaf[s]) begin
        tree_leaves.push_back(slot_idx[s]);
        send_node(slot_idx[s], slot_idx[$urandom_range(0, n_slots - 1)],
                  slot_idx[$urandom_range(0, n_slots - 1)], 1'b1,
                  SYM_W'($urandom));
      end else begin
        send_node(slot_idx[s], slot_idx[lc[s]], slot_idx[rc[s]], 1'b0,
                  SYM_W'($urandom));
      end
    end
  endtask

  // One random phase: new tree, root moved to it, then a run of data bytes mixed with node writes.
  task automatic run_phase();
    idx_t root;
    int   leaves;
    int   n;
    int   roll;
    case ($urandom_range(0, 9))
      0:       root = '0;
      1:       root = '1;
      default: root = idx_t'($urandom);
    endcase
    leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
    load_tree(root, leaves);
    settle();
    set_root(root);
    n = $urandom_range(12, 28);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        // Relabel a leaf of the current tree.
        send_node(tree_leaves[$urandom_range(0, tree_leaves.size() - 1)], known_node(),
                  known_node(), 1'b1, SYM_W'($urandom));
      end else if (roll < 9) begin
        // Stray write anywhere in the table.
        send_node(idx_t'($urandom), known_node(), known_node(), 1'($urandom),
                  SYM_W'($urandom));
      end else if (roll < 80) begin
        send_data(BYTE_W'($urandom), CNT_W'(MAX_BITS));
      end else begin
        send_data(BYTE_W'($urandom), CNT_W'($urandom_range(0, 15)));
      end
    end
  endtask

  // Hand-built tree: 0 -> 0xFF, 10 -> 0x00, 11 -> 0xA5, with node indices at the table's extremes.
  task automatic test_fixed_tree();
    set_root('0);
    send_node(9'd0, 9'd511, 9'd5, 1'b0, 8'h12);
    send_node(9'd511, 9'd0, 9'd511, 1'b1, 8'hFF);
    send_node(9'd5, 9'd6, 9'd7, 1'b0, 8'h34);
    send_node(9'd6, 9'd0, 9'd0, 1'b1, 8'h00);
    send_node(9'd7, 9'd0, 9'd0, 1'b1, 8'hA5);
    send_data(8'h00, 4'd8);   // eight symbols from one byte
    send_data(8'hFF, 4'd8);
    send_data(8'hB4, 4'd8);
    send_data(8'hC3, 4'd0);   // nothing consumed
    send_data(8'h6D, 4'd15);  // count above eight is clipped
    send_data(8'hC0, 4'd3);
    send_data(8'h80, 4'd1);   // code left open across bytes
    send_data(8'h00, 4'd1);
    settle();
  endtask

  // Leaf as root, and a root change that leaves the walk where it is.
  task automatic test_root_moves();
    send_node(9'd300, 9'd511, 9'd7, 1'b1, 8'h3C);
    send_data(8'h80, 4'd1);
    settle();
    set_root(9'd300);
    send_data(8'h40, 4'd2);
    send_data(8'h5A, 4'd8);
    settle();
    set_root(9'd511);
    send_data(8'hE7, 4'd8);
    send_data(8'h29, 4'd7);
    settle();
  endtask

  task automatic test_random_trees();
    while (beats_sent < 290) run_phase();
    settle();
  endtask

  task automatic test_no_idle_stretch();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    while (beats_sent < 360) run_phase();
    settle();
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  // Output side: random back-pressure while output gaps are on.
  always @(negedge clk_i) begin
    out_ready_i <= !(out_gaps && ($urandom_range(0, 99) < 23));
  end

  // Compare every accepted output beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (symbols_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat symbol %02h last %0b",
                                  out_data_o.symbol, out_data_o.last));
      end else begin
        due_beat = symbols_due.pop_front();
        if (out_data_o.symbol !== due_beat.symbol)
          report_mismatch($sformatf("symbol %02h, expected %02h",
                                    out_data_o.symbol, due_beat.symbol));
        if (out_data_o.last !== due_beat.last)
          report_mismatch($sformatf("last %0b, expected %0b on symbol %02h",
                                    out_data_o.last, due_beat.last, due_beat.symbol));
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("huffman_tree_walk_decoder_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    mismatches  = 0;
    beats_sent  = 0;
    in_gaps     = 1'b1;
    out_gaps    = 1'b1;
    walk_mirror = '0;
    root_mirror = '0;
    node_known  = '{default: 1'b0};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fixed_tree();
    test_root_moves();
    test_random_trees();
    test_no_idle_stretch();

    settle();
    if (mismatches == 0) begin
      $display("huffman_tree_walk_decoder_unit_tb OK");
    end else begin
      $display("huffman_tree_walk_decoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
